FILE: sv/u8g_pkg.sv
`default_nettype none
package u8g_pkg;

  typedef enum logic [1:0] {
    ST_GLYPH    = 2'd0,
    ST_INVALID  = 2'd1,
    ST_NOGLYPH  = 2'd2,
    ST_REJECTED = 2'd3
  } status_t;

  typedef logic [20:0] cp_t;

  // bit 8 marks a mapped entry, bits 7..0 carry the glyph
  typedef logic [8:0] map_entry_t;

  typedef struct packed {
    logic [7:0]  glyph;
    status_t     status;
    cp_t         codepoint;
    logic [15:0] error_offset;
    logic        end_of_string;
  } result_t;

  localparam cp_t CP_MAX     = 21'h10FFFF;
  localparam cp_t SURR_LO    = 21'h00D800;
  localparam cp_t SURR_HI    = 21'h00DFFF;
  localparam cp_t MIN_TWO    = 21'h000080;
  localparam cp_t MIN_THREE  = 21'h000800;
  localparam cp_t MIN_FOUR   = 21'h010000;
  localparam cp_t CP_IEXCL   = 21'h0000A1;
  localparam cp_t CP_IQUES   = 21'h0000BF;
  localparam logic [7:0] GLYPH_IEXCL     = 8'd0;
  localparam logic [7:0] GLYPH_IQUES     = 8'd1;
  localparam logic [7:0] GLYPH_BACKSLASH = 8'd222;

  localparam map_entry_t UPPER_TAB [32] = '{
    9'd259, 9'd260, 9'd261, 9'd262, 9'd258, 9'd263, 9'd418, 9'd264,
    9'd265, 9'd266, 9'd267, 9'd268, 9'd269, 9'd270, 9'd271, 9'd272,
    9'd273, 9'd274, 9'd275, 9'd276, 9'd277, 9'd278, 9'd279, 9'd0,
    9'd280, 9'd281, 9'd282, 9'd283, 9'd284, 9'd406, 9'd286, 9'd285
  };

  localparam map_entry_t LOWER_TAB [32] = '{
    9'd287, 9'd291, 9'd292, 9'd347, 9'd349, 9'd350, 9'd419, 9'd352,
    9'd379, 9'd380, 9'd381, 9'd382, 9'd385, 9'd386, 9'd387, 9'd388,
    9'd390, 9'd391, 9'd392, 9'd393, 9'd394, 9'd395, 9'd396, 9'd0,
    9'd397, 9'd398, 9'd399, 9'd401, 9'd402, 9'd403, 9'd405, 9'd404
  };

endpackage
`default_nettype wire

FILE: sv/u8g_in_if.sv
`default_nettype none
interface u8g_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

FILE: sv/u8g_out_if.sv
`default_nettype none
interface u8g_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  glyph;
  logic [1:0]  status;
  logic [20:0] codepoint;
  logic [15:0] error_offset;
  logic        end_of_string;

  modport source (output valid, output glyph, output status, output codepoint,
                  output error_offset, output end_of_string, input ready);
  modport sink   (input valid, input glyph, input status, input codepoint,
                  input error_offset, input end_of_string, output ready);
endinterface
`default_nettype wire

FILE: sv/u8g_glyph_map.sv
`default_nettype none
module u8g_glyph_map import u8g_pkg::*; (
  input  cp_t        cp,
  output logic       mapped,
  output logic [7:0] glyph
);

  map_entry_t ent;

  always_comb begin
    ent = '0;
    if (cp[20:7] == '0) begin
      case (cp[6:0])
        7'd35, 7'd36, 7'd91, 7'd93, 7'd94, 7'd96: ent = '0;
        7'd92: ent = {1'b1, GLYPH_BACKSLASH};
        default: begin
          if (cp[6:0] >= 7'd32 && cp[6:0] <= 7'd122) ent = {1'b1, 1'b0, cp[6:0]};
          else ent = '0;
        end
      endcase
    end else if (cp == CP_IEXCL) begin
      ent = {1'b1, GLYPH_IEXCL};
    end else if (cp == CP_IQUES) begin
      ent = {1'b1, GLYPH_IQUES};
    end else if (cp[20:8] == '0 && cp[7:6] == 2'b11) begin
      ent = cp[5] ? LOWER_TAB[cp[4:0]] : UPPER_TAB[cp[4:0]];
    end
  end

  assign mapped = ent[8];
  assign glyph  = ent[7:0];

endmodule
`default_nettype wire

FILE: sv/utf8_to_glyph_transcoder.sv
// Strict UTF-8 to font glyph transcoder. Bytes of a string arrive one word at a
// time with last_byte on the final one; each completed code point yields one
// result word (glyph, or no-glyph with its code point), the first malformed
// sequence yields one invalid word with its start offset, and after an error the
// string's remaining bytes are dropped until the final byte, which yields a status
// 3 word. Throughput is one byte per cycle while the skid word is empty: decode
// and table lookup sit between the accepted byte and the output register, and a
// one-word skid buffer keeps input ready while a result waits. Byte offsets
// saturate at 2^POSITION_WIDTH-1 and are reported in their low 16 bits.
`default_nettype none
module utf8_to_glyph_transcoder import u8g_pkg::*; #(
  parameter int POSITION_WIDTH = 16
) (
  input  wire          clk,
  input  wire          rst_n,
  u8g_in_if.sink       in_bus,
  u8g_out_if.source    out_bus
);

  localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

  cp_t                      acc_r, acc_nxt;
  logic [1:0]               left_r, left_nxt;
  logic [1:0]               len_r, len_nxt;
  logic [POSITION_WIDTH-1:0] start_r, start_nxt;
  logic [POSITION_WIDTH-1:0] pos_r, pos_nxt;
  logic                     rej_r, rej_nxt;

  result_t                  out_r, skid_r, res;
  logic                     out_valid_r, skid_valid_r;
  logic                     has_res;

  logic                     accept, pop, last;
  logic [7:0]               b;
  cp_t                      cp_cont, map_cp;
  logic                     map_ok;
  logic [7:0]               map_glyph;
  logic [POSITION_WIDTH-1:0] start_cur;
  logic [1:0]               extra;
  cp_t                      lead_acc;
  logic                     bad;
  logic                     do_finish, do_invalid;

  assign b      = in_bus.data_byte;
  assign last   = in_bus.last_byte;
  assign accept = in_bus.valid && in_bus.ready;
  assign pop    = out_valid_r && out_bus.ready;

  assign in_bus.ready = !skid_valid_r;

  assign cp_cont   = {acc_r[14:0], b[5:0]};
  assign map_cp    = (left_r == 2'd0) ? {13'd0, b} : cp_cont;
  assign start_cur = (left_r == 2'd0) ? pos_r : start_r;

  u8g_glyph_map u_map (
    .cp     (map_cp),
    .mapped (map_ok),
    .glyph  (map_glyph)
  );

  always_comb begin
    extra    = 2'd0;
    lead_acc = '0;
    if (b[7:5] == 3'b110) begin
      extra = 2'd1; lead_acc = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      extra = 2'd2; lead_acc = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      extra = 2'd3; lead_acc = {18'd0, b[2:0]};
    end
  end

  always_comb begin
    bad = (len_r == 2'd1 && cp_cont < MIN_TWO) ||
          (len_r == 2'd2 && cp_cont < MIN_THREE) ||
          (len_r == 2'd3 && cp_cont < MIN_FOUR) ||
          (cp_cont >= SURR_LO && cp_cont <= SURR_HI) ||
          cp_cont > CP_MAX;
  end

  always_comb begin
    acc_nxt    = acc_r;
    left_nxt   = left_r;
    len_nxt    = len_r;
    start_nxt  = start_r;
    rej_nxt    = rej_r;
    pos_nxt    = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;
    has_res    = 1'b0;
    do_finish  = 1'b0;
    do_invalid = 1'b0;
    res        = '0;
    res.end_of_string = last;

    if (rej_r) begin
      if (last) begin
        has_res    = 1'b1;
        res.status = ST_REJECTED;
      end
    end else if (left_r == 2'd0) begin
      start_nxt = pos_r;
      if (!b[7]) begin
        do_finish = 1'b1;
      end else if (extra == 2'd0 || last) begin
        do_invalid = 1'b1;
      end else begin
        acc_nxt  = lead_acc;
        left_nxt = extra;
        len_nxt  = extra;
      end
    end else if (b[7:6] != 2'b10) begin
      do_invalid = 1'b1;
    end else begin
      acc_nxt  = cp_cont;
      left_nxt = left_r - 2'd1;
      if (left_r == 2'd1) begin
        if (bad) do_invalid = 1'b1;
        else     do_finish  = 1'b1;
      end else if (last) begin
        do_invalid = 1'b1;
      end
    end

    if (do_invalid) begin
      has_res          = 1'b1;
      rej_nxt          = 1'b1;
      left_nxt         = 2'd0;
      res.status       = ST_INVALID;
      res.error_offset = 16'(start_cur);
    end else if (do_finish) begin
      has_res       = 1'b1;
      res.codepoint = map_cp;
      if (map_ok) begin
        res.status = ST_GLYPH;
        res.glyph  = map_glyph;
      end else begin
        rej_nxt          = 1'b1;
        res.status       = ST_NOGLYPH;
        res.error_offset = 16'(start_cur);
      end
    end

    if (last) begin
      acc_nxt   = '0;
      left_nxt  = 2'd0;
      len_nxt   = 2'd0;
      start_nxt = '0;
      pos_nxt   = '0;
      rej_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      left_r  <= 2'd0;
      len_r   <= 2'd0;
      start_r <= '0;
      pos_r   <= '0;
      rej_r   <= 1'b0;
    end else if (accept) begin
      acc_r   <= acc_nxt;
      left_r  <= left_nxt;
      len_r   <= len_nxt;
      start_r <= start_nxt;
      pos_r   <= pos_nxt;
      rej_r   <= rej_nxt;
    end
  end

  // output word plus one skid word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || pop) begin
      out_valid_r <= accept && has_res;
    end else if (accept && has_res) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) out_r <= skid_r;
    end else if (!out_valid_r || pop) begin
      out_r <= res;
    end else if (accept && has_res) begin
      skid_r <= res;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.glyph         = out_r.glyph;
  assign out_bus.status        = out_r.status;
  assign out_bus.codepoint     = out_r.codepoint;
  assign out_bus.error_offset  = out_r.error_offset;
  assign out_bus.end_of_string = out_r.end_of_string;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held without output word");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last) |=> (left_r == 2'd0 && !rej_r && pos_r == '0))
    else $error("string state not cleared after final byte");

  a_pending_not_rejected: assert property (@(posedge clk) disable iff (!rst_n)
    (left_r != 2'd0) |-> !rej_r)
    else $error("sequence pending in rejected string");

  a_rejected_word_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && has_res && res.status == ST_REJECTED) |-> res.end_of_string)
    else $error("status 3 word not at string end");

endmodule
`default_nettype wire
